### hdl/ced_pkg.sv
// ----------------------------------------------------------------------------
// ced_pkg: shared types and constants for the 3x3 color edge detector
// Pixel layout, control bundles, register indexes and the channel compare.
// ----------------------------------------------------------------------------
package ced_pkg;

   localparam int CH_W   = 8;
   localparam int NUM_CH = 3;
   localparam int PIX_W  = CH_W * NUM_CH;

   typedef logic [PIX_W-1:0] pixel_type;

   localparam pixel_type COLOR_WHITE = 24'hFFFFFF;
   localparam pixel_type COLOR_BLACK = 24'h000000;

   // item kinds carried on req_tuser
   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic [CH_W-1:0]       THRESHOLD_RESET = 8'd1;
   localparam logic [CSR_DATA_W-1:0] WIDTH_RESET     = 11'd1024;
   localparam logic [CSR_DATA_W-1:0] HEIGHT_RESET    = 11'd1024;

   // result queue
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_DEPTH = 1 << FIFO_PTR_W;
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   // per-item control that follows the pixel column down the pipeline
   typedef struct packed {
      logic emit;
      logic done;
      logic top_ok;
      logic bot_ok;
      logic left_ok;
      logic right_ok;
   } ctrl_type;

   typedef struct packed {
      logic is_edge;
      logic frame_done;
   } result_type;

   // true when any channel differs by more than thr
   function automatic logic px_differs(input pixel_type a, input pixel_type b,
                                       input logic [CH_W-1:0] thr);
      logic [CH_W-1:0] x;
      logic [CH_W-1:0] y;
      logic [CH_W-1:0] d;
      logic            hit;
      hit = 1'b0;
      for (int k = 0; k < NUM_CH; k++) begin
         x = a[k*CH_W +: CH_W];
         y = b[k*CH_W +: CH_W];
         d = (x > y) ? (x - y) : (y - x);
         if (d > thr) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

### hdl/color_edge_detect_3x3.sv
// Path: an item that completes its window passes the stage 1 registers, then the
//   stage 2 window and control registers, and is written into the 4-entry result
//   queue, where it is valid on rsp and may wait until rsp_tready takes it.
// Throughput: one item per cycle while the result queue has room; each row store
//   has one registered read port, and a back-to-back same-column hit is forwarded.
// Reset: clears counters, window, pipeline and queue, loads register defaults;
//   row store contents are left as they are.
// ----------------------------------------------------------------------------
// color_edge_detect_3x3: streaming 3x3 color edge detector
// Raster RGB pixels in, black/white edge classification out, one row behind.
// ----------------------------------------------------------------------------
module color_edge_detect_3x3 import ced_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   // input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // red[7:0], green[15:8], blue[23:16]
   input  logic                  req_tuser,   // action[0]
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // out_pixel[23:0]
   output logic                  rsp_tuser,   // is_edge[0]
   output logic                  rsp_tlast,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
   localparam logic [ROW_W:0]   ROWX_ONE = (ROW_W + 1)'(1);
   localparam logic [ROW_W:0]   ROWX_TWO = (ROW_W + 1)'(2);
   localparam logic [ROW_W-1:0] ROW_ONE  = ROW_W'(1);
   localparam logic [COL_W-1:0] COL_ONE  = COL_W'(1);

   // registers
   logic [CH_W-1:0]       threshold_ff;
   logic [CSR_DATA_W-1:0] width_ff;
   logic [CSR_DATA_W-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD:    threshold_ff <= csr_data[CH_W-1:0];
            CSR_IMAGE_WIDTH:  width_ff     <= csr_data;
            CSR_IMAGE_HEIGHT: height_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // effective frame size
   logic [COL_W-1:0] wlast;
   logic [ROW_W-1:0] hval;

   always_comb begin
      if (width_ff == '0) begin
         wlast = '0;
      end else if (32'(width_ff) > MAX_WIDTH) begin
         wlast = COL_W'(MAX_WIDTH - 1);
      end else begin
         wlast = COL_W'(32'(width_ff) - 32'd1);
      end
      if (height_ff == '0) begin
         hval = ROW_ONE;
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         hval = ROW_W'(MAX_HEIGHT);
      end else begin
         hval = ROW_W'(height_ff);
      end
   end

   // input step
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             req_acc, in_frame, noop, step;
   logic [COL_W-1:0] col_c;
   logic             col0;
   pixel_type        pix;
   logic [ROW_W:0]   rowx, hx, pr_off;
   logic [ROW_W-1:0] prv;
   logic             over;
   ctrl_type         step_ctrl;

   always_comb begin
      req_acc  = req_tvalid && req_tready;
      in_frame = row_ff < hval;
      noop     = (req_tuser == ACT_FLUSH) && in_frame;
      step     = req_acc && !noop;
      col_c    = (col_ff > wlast) ? wlast : col_ff;
      col0     = (col_c == '0);
      // pixels past the frame count as flush steps
      pix      = in_frame ? {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]} : '0;
      rowx     = {1'b0, row_ff};
      hx       = {1'b0, hval};
      // end of row: finish the last pixel of the row above
      pr_off   = col0 ? ROWX_TWO : ROWX_ONE;
      prv      = ROW_W'(rowx - pr_off);
      over     = rowx >= (hx + pr_off);

      step_ctrl.emit     = (rowx >= pr_off) && !over;
      step_ctrl.top_ok   = (prv != '0);
      step_ctrl.bot_ok   = (prv != (hval - ROW_ONE));
      step_ctrl.left_ok  = col0 ? (wlast != '0) : (col_c != COL_ONE);
      step_ctrl.right_ok = !col0;
      step_ctrl.done     = step_ctrl.emit && col0 && (prv == (hval - ROW_ONE));

      col_in = col_ff;
      row_in = row_ff;
      if (step) begin
         if (step_ctrl.done || over) begin
            col_in = '0;
            row_in = '0;
         end else if (col_c == wlast) begin
            col_in = '0;
            row_in = row_ff + ROW_ONE;
         end else begin
            col_in = col_c + COL_ONE;
         end
      end
   end

   // stage 1: row store read data returns
   logic             s1_v_ff;
   ctrl_type         s1_ctrl_ff;
   logic [COL_W-1:0] s1_col_ff;
   pixel_type        s1_pix_ff;
   logic             hit_ff;
   pixel_type        hit_top_ff, hit_mid_ff;
   pixel_type        upper_rd_ff, middle_rd_ff;
   pixel_type        s1_top, s1_mid;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         s1_v_ff    <= 1'b0;
         s1_ctrl_ff <= '0;
         hit_ff     <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         s1_v_ff    <= step;
         s1_ctrl_ff <= step ? step_ctrl : '0;
         // same column written this cycle: the read misses it, forward it
         hit_ff     <= step && s1_v_ff && (s1_col_ff == col_c);
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         s1_col_ff <= col_c;
         s1_pix_ff <= pix;
      end
      hit_top_ff <= s1_mid;
      hit_mid_ff <= s1_pix_ff;
   end

   assign s1_top = hit_ff ? hit_top_ff : upper_rd_ff;
   assign s1_mid = hit_ff ? hit_mid_ff : middle_rd_ff;

   // row stores: read on accept, written back from stage 1 in the following cycle
   pixel_type upper_mem  [MAX_WIDTH];
   pixel_type middle_mem [MAX_WIDTH];

   always_ff @(posedge clock) begin
      if (step) begin
         upper_rd_ff  <= upper_mem[col_c];
         middle_rd_ff <= middle_mem[col_c];
      end
      if (s1_v_ff) begin
         upper_mem[s1_col_ff]  <= s1_mid;
         middle_mem[s1_col_ff] <= s1_pix_ff;
      end
   end

   // stage 2: window and compare
   logic res_valid, res_edge, res_done;

   ced_edge_unit u_edge (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (s1_v_ff),
      .col_top   (s1_top),
      .col_mid   (s1_mid),
      .col_bot   (s1_pix_ff),
      .ctrl_in   (s1_ctrl_ff),
      .threshold (threshold_ff),
      .res_valid (res_valid),
      .res_edge  (res_edge),
      .res_done  (res_done)
   );

   // result queue
   result_type            fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] fifo_cnt_ff, fifo_cnt_in;
   logic [FIFO_CNT_W-1:0] occupancy;
   logic                  fifo_pop;
   result_type            head;

   assign fifo_pop = rsp_tvalid && rsp_tready;

   always_comb begin
      case ({res_valid, fifo_pop})
         2'b10:   fifo_cnt_in = fifo_cnt_ff + FIFO_CNT_W'(1);
         2'b01:   fifo_cnt_in = fifo_cnt_ff - FIFO_CNT_W'(1);
         default: fifo_cnt_in = fifo_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         fifo_cnt_ff <= fifo_cnt_in;
         if (res_valid) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (fifo_pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         fifo_ff[wr_ptr_ff] <= '{is_edge: res_edge, frame_done: res_done};
      end
   end

   // hold input while queued plus in-flight results would fill the queue
   assign occupancy  = fifo_cnt_ff + FIFO_CNT_W'(s1_ctrl_ff.emit) + FIFO_CNT_W'(res_valid);
   assign req_tready = occupancy < FIFO_CNT_W'(FIFO_DEPTH);

   assign head       = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = (fifo_cnt_ff != '0);
   assign rsp_tdata  = head.is_edge ? COLOR_BLACK : COLOR_WHITE;
   assign rsp_tuser  = head.is_edge;
   assign rsp_tlast  = head.frame_done;

`ifndef NO_ASSERTIONS
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !fifo_pop) |-> (fifo_cnt_ff < FIFO_CNT_W'(FIFO_DEPTH)))
      else $error("result queue overflow");

   a_frame_end_rewinds: assert property (@(posedge clock) disable iff (reset)
      (step && step_ctrl.done) |=> (col_ff == '0 && row_ff == '0))
      else $error("position counters not rewound after frame end");

   a_emit_reaches_compare: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s1_ctrl_ff.emit) |=> res_valid)
      else $error("emitting step lost between row store and compare");
`endif

endmodule

### hdl/ced_edge_unit.sv
// ----------------------------------------------------------------------------
// ced_edge_unit: 3x3 pixel window and neighborhood compare
// Shifts one pixel column in per step and classifies the center pixel.
// ----------------------------------------------------------------------------
module ced_edge_unit import ced_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            shift_en,
   input  pixel_type       col_top,
   input  pixel_type       col_mid,
   input  pixel_type       col_bot,
   input  ctrl_type        ctrl_in,
   input  logic [CH_W-1:0] threshold,
   output logic            res_valid,
   output logic            res_edge,
   output logic            res_done
);

   pixel_type win_ff [3][3];
   ctrl_type  s2_ctrl_ff;
   logic      row_ok [3];
   logic      col_ok [3];
   logic      edge_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff     <= '{default: '0};
         s2_ctrl_ff <= '0;
      end else begin
         s2_ctrl_ff <= shift_en ? ctrl_in : '0;
         if (shift_en) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[r][0] <= win_ff[r][1];
               win_ff[r][1] <= win_ff[r][2];
            end
            win_ff[0][2] <= col_top;
            win_ff[1][2] <= col_mid;
            win_ff[2][2] <= col_bot;
         end
      end
   end

   // center always sits in the middle column once the step's column is in
   always_comb begin
      row_ok[0] = s2_ctrl_ff.top_ok;
      row_ok[1] = 1'b1;
      row_ok[2] = s2_ctrl_ff.bot_ok;
      col_ok[0] = s2_ctrl_ff.left_ok;
      col_ok[1] = 1'b1;
      col_ok[2] = s2_ctrl_ff.right_ok;
      edge_hit  = 1'b0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (!(i == 1 && j == 1) && row_ok[i] && col_ok[j] &&
                px_differs(win_ff[1][1], win_ff[i][j], threshold)) begin
               edge_hit = 1'b1;
            end
         end
      end
   end

   assign res_valid = s2_ctrl_ff.emit;
   assign res_edge  = edge_hit;
   assign res_done  = s2_ctrl_ff.done;

endmodule
